// File: rtl/kcl_pkg.sv
// Shared types and constants for the keypad code lock with sum challenge.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package kcl_pkg;

	localparam int ENTRY_DEPTH_DEF = 16;
	localparam int CODE_DIGITS_DEF = 6;

	localparam int KEY_W     = 4;
	localparam int RAND_W    = 14;
	localparam int EV_W      = 3;
	localparam int COUNT_W   = 5;
	localparam int FAIL_W    = 4;
	localparam int CODE_W    = 24;
	localparam int CLEN_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int ALU_W     = 17;
	localparam int NIB_W     = 3;
	localparam int BIT_W     = 4;

	localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
	localparam logic [KEY_W-1:0] KEY_BACKSPACE = 4'd10;
	localparam logic [KEY_W-1:0] KEY_ENTER     = 4'd11;

	localparam logic [RAND_W-1:0] CHAL_RANGE   = 14'd10000;
	localparam logic [ALU_W-1:0]  VAL_CAP      = 17'd100000;
	localparam logic [ALU_W-1:0]  VAL_SAT_FROM = 17'd10000;
	localparam logic [FAIL_W-1:0] FAIL_MAX     = 4'hF;

	localparam logic [CFG_IDX_W-1:0] CFG_CODE_BCD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT  = 2'd2;

	localparam logic [CODE_W-1:0] CODE_BCD_RST    = 24'h000741;
	localparam logic [CLEN_W-1:0] CODE_LENGTH_RST = 3'd3;
	localparam logic [FAIL_W-1:0] FAIL_LIMIT_RST  = 4'd3;

	typedef enum logic [EV_W-1:0] {
		EV_DIGIT,
		EV_DELETED,
		EV_UNLOCKED,
		EV_WRONG,
		EV_PASSED,
		EV_CLOSED,
		EV_IGNORED
	} kcl_event_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SUM,
		S_READ,
		S_MUL,
		S_ADD,
		S_CMP,
		S_CHECK,
		S_MOD1,
		S_DSUB,
		S_DIV,
		S_FINISH
	} kcl_state_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} kcl_alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] sum;
		logic             carry;
		logic             zero;
	} kcl_alu_rsp_t;

endpackage

`default_nettype wire

// File: rtl/kcl_if.sv
// Valid/ready channel interfaces for keypad events and lock results.
// Depends on kcl_pkg for field widths.
`default_nettype none

interface kcl_in_if;
	logic                      valid;
	logic                      ready;
	logic [kcl_pkg::KEY_W-1:0]  key_code;
	logic [kcl_pkg::RAND_W-1:0] rand_first;
	logic [kcl_pkg::RAND_W-1:0] rand_second;

	modport source (output valid, key_code, rand_first, rand_second, input ready);
	modport sink (input valid, key_code, rand_first, rand_second, output ready);
endinterface

interface kcl_out_if;
	logic                       valid;
	logic                       ready;
	logic [kcl_pkg::EV_W-1:0]    event_res;
	logic [kcl_pkg::COUNT_W-1:0] entry_count;
	logic                       door_open;
	logic                       challenge_mode;
	logic [kcl_pkg::RAND_W-1:0]  challenge_first;
	logic [kcl_pkg::RAND_W-1:0]  challenge_second;
	logic [kcl_pkg::FAIL_W-1:0]  failures;

	modport source (output valid, event_res, entry_count, door_open, challenge_mode,
		challenge_first, challenge_second, failures, input ready);
	modport sink (input valid, event_res, entry_count, door_open, challenge_mode,
		challenge_first, challenge_second, failures, output ready);
endinterface

`default_nettype wire

// File: rtl/kcl_alu.sv
// Shared add/subtract unit with carry and zero flags.
// Depends on kcl_pkg for the request and response structs.
`default_nettype none

module kcl_alu (
	input  kcl_pkg::kcl_alu_req_t req,
	output kcl_pkg::kcl_alu_rsp_t rsp
);

	logic [kcl_pkg::ALU_W-1:0] b_op;
	logic [kcl_pkg::ALU_W:0]   full;

	// subtract as a + ~b + 1; carry high then means a >= b
	assign b_op = req.sub ? ~req.b : req.b;
	assign full = {1'b0, req.a} + {1'b0, b_op} + {{kcl_pkg::ALU_W{1'b0}}, req.sub};

	assign rsp.sum   = full[kcl_pkg::ALU_W-1:0];
	assign rsp.carry = full[kcl_pkg::ALU_W];
	assign rsp.zero  = (full[kcl_pkg::ALU_W-1:0] == '0);

endmodule

`default_nettype wire

// File: rtl/keypad_code_lock_with_challenge_top.sv
// Keypad code lock with sum challenge: sequencer, entry memory and state registers.
// Depends on kcl_pkg, kcl_if.sv (channel interfaces) and kcl_alu (shared adder).
//
//  Port     Dir  Transfer on        Carries
//  keys     in   valid & ready      key_code, rand_first, rand_second
//  result   out  valid & ready      event_res, entry_count, door_open, challenge_mode,
//                                   challenge_first, challenge_second, failures
//  cfg_*    in   cfg_we             cfg_index selects code_bcd, code_length, fail_limit
//
// Digit, backspace, ignored keys and enter while open pass idle, decode and finish.
// Enter while closed: the code check compares each held digit (a length mismatch skips
// the compare), the challenge check builds the entered value. Both end in a 14-step
// remainder for the challenge redraw; all arithmetic goes through one adder.
// Reset clears the lock state and loads the default code; no clearing pass.
// keys.ready is high only in idle; a finished result waits in the output
// register and does not block the next transfer on keys.
`default_nettype none

module keypad_code_lock_with_challenge_top #(
	parameter int ENTRY_DEPTH = kcl_pkg::ENTRY_DEPTH_DEF,
	parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [kcl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [kcl_pkg::CODE_W-1:0]        cfg_data,
	kcl_in_if.sink                                 keys,
	kcl_out_if.source                              result
);

	localparam int LEN_W  = $clog2(ENTRY_DEPTH + 1);
	localparam int ADDR_W = $clog2(ENTRY_DEPTH);
	localparam int ALU_W  = kcl_pkg::ALU_W;
	localparam int RAND_W = kcl_pkg::RAND_W;

	kcl_pkg::kcl_state_t state_q, state_d;

	// configuration
	logic [kcl_pkg::CODE_W-1:0] code_q;
	logic [kcl_pkg::CLEN_W-1:0] clen_q;
	logic [kcl_pkg::FAIL_W-1:0] flim_q;

	// lock state
	logic [LEN_W-1:0]           len_q;
	logic [kcl_pkg::FAIL_W-1:0] fail_q;
	logic                       door_q;
	logic [RAND_W-1:0]          cf_q;
	logic [RAND_W-1:0]          cs_q;

	// sequencer
	logic                       chal_q;
	logic                       match_q;
	logic [LEN_W-1:0]           idx_q;
	logic [kcl_pkg::NIB_W-1:0]  nib_q;
	logic [kcl_pkg::BIT_W-1:0]  bit_q;
	kcl_pkg::kcl_event_t        ev_q;
	logic                       out_valid_q;

	// item and working registers
	logic [kcl_pkg::KEY_W-1:0]  key_q;
	logic [RAND_W-1:0]          r1_q;
	logic [RAND_W-1:0]          r2_q;
	logic [ALU_W-1:0]           acc_q;
	logic [ALU_W-1:0]           tmp_q;
	logic [ALU_W-1:0]           tgt_q;
	logic [RAND_W-1:0]          cfn_q;
	logic [RAND_W-1:0]          div_q;
	logic [RAND_W-1:0]          rem_q;
	logic [kcl_pkg::KEY_W-1:0]  rd_q;
	logic [kcl_pkg::KEY_W-1:0]  mem [ENTRY_DEPTH];

	// result register
	kcl_pkg::kcl_event_t        ev_out_q;
	logic [kcl_pkg::COUNT_W-1:0] cnt_out_q;
	logic                       door_out_q;
	logic                       chal_out_q;
	logic [RAND_W-1:0]          cf_out_q;
	logic [RAND_W-1:0]          cs_out_q;
	logic [kcl_pkg::FAIL_W-1:0] fail_out_q;

	kcl_pkg::kcl_alu_req_t alu_req;
	kcl_pkg::kcl_alu_rsp_t alu_rsp;

	logic                       accept;
	logic                       out_load;
	logic                       chal_now;
	logic [3:0]                 clen_eff;
	logic                       len_ok;
	logic [31:0]                code_w;
	logic [kcl_pkg::KEY_W-1:0]  code_nib;
	logic [RAND_W:0]            shifted;
	logic [RAND_W-1:0]          rem_next;
	logic [31:0]                len_w;

	kcl_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign accept   = keys.valid && keys.ready;
	assign out_load = (state_q == kcl_pkg::S_FINISH) && (state_d == kcl_pkg::S_IDLE);
	assign chal_now = (fail_q >= flim_q);
	assign clen_eff = ({1'b0, clen_q} > 4'(CODE_DIGITS)) ? 4'(CODE_DIGITS) : {1'b0, clen_q};
	assign len_ok   = (32'(len_q) == 32'(clen_eff));
	assign code_w   = 32'(code_q);
	assign code_nib = code_w[{nib_q, 2'b00} +: 4];
	assign shifted  = {rem_q, r2_q[bit_q]};
	assign rem_next = alu_rsp.carry ? alu_rsp.sum[RAND_W-1:0] : shifted[RAND_W-1:0];
	assign len_w    = 32'(len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kcl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		alu_req = '{a: '0, b: '0, sub: 1'b0};
		unique case (state_q)
			kcl_pkg::S_IDLE: begin
				if (keys.valid) state_d = kcl_pkg::S_DECODE;
			end
			kcl_pkg::S_DECODE: begin
				if (door_q || key_q != kcl_pkg::KEY_ENTER) state_d = kcl_pkg::S_FINISH;
				else if (chal_now) state_d = kcl_pkg::S_SUM;
				else if (len_ok) state_d = kcl_pkg::S_READ;
				else state_d = kcl_pkg::S_MOD1;
			end
			kcl_pkg::S_SUM: begin
				alu_req = '{a: ALU_W'(cf_q), b: ALU_W'(cs_q), sub: 1'b0};
				state_d = kcl_pkg::S_READ;
			end
			kcl_pkg::S_READ: begin
				if (idx_q == len_q) state_d = chal_q ? kcl_pkg::S_CHECK : kcl_pkg::S_MOD1;
				else state_d = chal_q ? kcl_pkg::S_MUL : kcl_pkg::S_CMP;
			end
			kcl_pkg::S_MUL: begin
				// times ten as 8v + 2v
				alu_req = '{a: {acc_q[ALU_W-4:0], 3'b000}, b: {acc_q[ALU_W-2:0], 1'b0},
					sub: 1'b0};
				state_d = kcl_pkg::S_ADD;
			end
			kcl_pkg::S_ADD: begin
				alu_req = '{a: tmp_q, b: ALU_W'(rd_q), sub: 1'b0};
				state_d = kcl_pkg::S_READ;
			end
			kcl_pkg::S_CMP: begin
				alu_req = '{a: ALU_W'(rd_q), b: ALU_W'(code_nib), sub: 1'b1};
				state_d = kcl_pkg::S_READ;
			end
			kcl_pkg::S_CHECK: begin
				alu_req = '{a: acc_q, b: tgt_q, sub: 1'b1};
				state_d = kcl_pkg::S_MOD1;
			end
			kcl_pkg::S_MOD1: begin
				alu_req = '{a: ALU_W'(r1_q), b: ALU_W'(kcl_pkg::CHAL_RANGE), sub: 1'b1};
				state_d = kcl_pkg::S_DSUB;
			end
			kcl_pkg::S_DSUB: begin
				alu_req = '{a: ALU_W'(kcl_pkg::CHAL_RANGE), b: ALU_W'(cfn_q), sub: 1'b1};
				state_d = kcl_pkg::S_DIV;
			end
			kcl_pkg::S_DIV: begin
				alu_req = '{a: ALU_W'(shifted), b: ALU_W'(div_q), sub: 1'b1};
				if (bit_q == '0) state_d = kcl_pkg::S_FINISH;
			end
			kcl_pkg::S_FINISH: begin
				if (!out_valid_q || result.ready) state_d = kcl_pkg::S_IDLE;
			end
			default: state_d = kcl_pkg::S_IDLE;
		endcase
	end

	// control and lock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q      <= kcl_pkg::CODE_BCD_RST;
			clen_q      <= kcl_pkg::CODE_LENGTH_RST;
			flim_q      <= kcl_pkg::FAIL_LIMIT_RST;
			len_q       <= '0;
			fail_q      <= '0;
			door_q      <= 1'b0;
			cf_q        <= '0;
			cs_q        <= '0;
			chal_q      <= 1'b0;
			match_q     <= 1'b0;
			idx_q       <= '0;
			nib_q       <= '0;
			bit_q       <= '0;
			ev_q        <= kcl_pkg::EV_IGNORED;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					kcl_pkg::CFG_CODE_BCD:    code_q <= cfg_data;
					kcl_pkg::CFG_CODE_LENGTH: clen_q <= cfg_data[kcl_pkg::CLEN_W-1:0];
					kcl_pkg::CFG_FAIL_LIMIT:  flim_q <= cfg_data[kcl_pkg::FAIL_W-1:0];
					default: ;
				endcase
			end

			if (out_load) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;

			case (state_q)
				kcl_pkg::S_DECODE: begin
					chal_q  <= chal_now;
					// a length mismatch skips the digit compare and must fail
					match_q <= len_ok;
					idx_q   <= '0;
					nib_q   <= kcl_pkg::NIB_W'(clen_eff - 4'd1);
					ev_q    <= kcl_pkg::EV_IGNORED;
					if (door_q) begin
						if (key_q == kcl_pkg::KEY_ENTER) begin
							door_q <= 1'b0;
							ev_q   <= kcl_pkg::EV_CLOSED;
						end
					end else if (key_q <= kcl_pkg::KEY_DIGIT_MAX) begin
						if (len_q != LEN_W'(ENTRY_DEPTH)) begin
							len_q <= len_q + 1'b1;
							ev_q  <= kcl_pkg::EV_DIGIT;
						end
					end else if (key_q == kcl_pkg::KEY_BACKSPACE) begin
						if (len_q != '0) begin
							len_q <= len_q - 1'b1;
							ev_q  <= kcl_pkg::EV_DELETED;
						end
					end
				end
				kcl_pkg::S_ADD: idx_q <= idx_q + 1'b1;
				kcl_pkg::S_CMP: begin
					if (!alu_rsp.zero) match_q <= 1'b0;
					idx_q <= idx_q + 1'b1;
					nib_q <= nib_q - 1'b1;
				end
				kcl_pkg::S_CHECK: match_q <= alu_rsp.zero;
				kcl_pkg::S_DSUB: bit_q <= kcl_pkg::BIT_W'(RAND_W - 1);
				kcl_pkg::S_DIV: begin
					if (bit_q != '0) begin
						bit_q <= bit_q - 1'b1;
					end else begin
						// commit the enter outcome and the new challenge
						cf_q  <= cfn_q;
						cs_q  <= rem_next;
						len_q <= '0;
						if (match_q) begin
							fail_q <= '0;
							if (chal_q) begin
								ev_q <= kcl_pkg::EV_PASSED;
							end else begin
								ev_q   <= kcl_pkg::EV_UNLOCKED;
								door_q <= 1'b1;
							end
						end else begin
							ev_q <= kcl_pkg::EV_WRONG;
							if (fail_q != kcl_pkg::FAIL_MAX) fail_q <= fail_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// item, working and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= keys.key_code;
			r1_q  <= keys.rand_first;
			r2_q  <= keys.rand_second;
		end
		case (state_q)
			kcl_pkg::S_SUM: begin
				tgt_q <= alu_rsp.sum;
				acc_q <= '0;
			end
			kcl_pkg::S_MUL: tmp_q <= alu_rsp.sum;
			kcl_pkg::S_ADD: acc_q <= (acc_q >= kcl_pkg::VAL_SAT_FROM) ? kcl_pkg::VAL_CAP
				: alu_rsp.sum;
			kcl_pkg::S_MOD1: cfn_q <= alu_rsp.carry ? alu_rsp.sum[RAND_W-1:0] : r1_q;
			kcl_pkg::S_DSUB: begin
				div_q <= alu_rsp.sum[RAND_W-1:0];
				rem_q <= '0;
			end
			kcl_pkg::S_DIV: rem_q <= rem_next;
			default: ;
		endcase
		if (out_load) begin
			ev_out_q   <= ev_q;
			cnt_out_q  <= len_w[kcl_pkg::COUNT_W-1:0];
			door_out_q <= door_q;
			chal_out_q <= chal_now;
			cf_out_q   <= cf_q;
			cs_out_q   <= cs_q;
			fail_out_q <= fail_q;
		end
	end

	// entry buffer
	always_ff @(posedge clk) begin
		if (state_q == kcl_pkg::S_DECODE && !door_q && key_q <= kcl_pkg::KEY_DIGIT_MAX
			&& len_q != LEN_W'(ENTRY_DEPTH)) begin
			mem[len_q[ADDR_W-1:0]] <= key_q;
		end
		rd_q <= mem[idx_q[ADDR_W-1:0]];
	end

	assign keys.ready              = (state_q == kcl_pkg::S_IDLE);
	assign result.valid            = out_valid_q;
	assign result.event_res        = ev_out_q;
	assign result.entry_count      = cnt_out_q;
	assign result.door_open        = door_out_q;
	assign result.challenge_mode   = chal_out_q;
	assign result.challenge_first  = cf_out_q;
	assign result.challenge_second = cs_out_q;
	assign result.failures         = fail_out_q;

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !keys.ready)
		else $error("keys.ready high right after a transfer");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(ENTRY_DEPTH))
		else $error("entry length beyond buffer depth");

	a_open_no_fail: assert property (@(posedge clk) disable iff (!arst_n)
		door_q |-> fail_q == '0)
		else $error("failure count nonzero while door open");

	a_chal_range: assert property (@(posedge clk) disable iff (!arst_n)
		(15'(cf_q) + 15'(cs_q)) < 15'(kcl_pkg::CHAL_RANGE))
		else $error("challenge operands out of range");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kcl_pkg::S_DIV |-> rem_q < div_q)
		else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

// File: verif/tb_keypad_code_lock_with_challenge_top.sv
// Self-checking bench for the keypad code lock: queued keypad events drive the keys channel,
// a built-in lock model predicts every result, and the result channel is compared field by field.
// Depends on kcl_pkg, the kcl_in_if/kcl_out_if interfaces and keypad_code_lock_with_challenge_top.

module tb_keypad_code_lock_with_challenge_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRY_DEPTH = kcl_pkg::ENTRY_DEPTH_DEF;
	localparam int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF;
	localparam int KEY_W = kcl_pkg::KEY_W;
	localparam int RAND_W = kcl_pkg::RAND_W;
	localparam int COUNT_W = kcl_pkg::COUNT_W;
	localparam int FAIL_W = kcl_pkg::FAIL_W;
	localparam int CODE_W = kcl_pkg::CODE_W;
	localparam int CLEN_W = kcl_pkg::CLEN_W;
	localparam int CFG_IDX_W = kcl_pkg::CFG_IDX_W;
	localparam int WATCHDOG_CYCLES = 5000;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int ITEMS_PER_SETTING = 80;
	localparam int NUM_SETTINGS = 6;
	localparam logic [KEY_W-1:0] KEY_UNUSED_LO = 4'd12;
	localparam logic [KEY_W-1:0] KEY_UNUSED_HI = 4'd15;

	typedef struct packed {
		logic [KEY_W-1:0]  key_code;
		logic [RAND_W-1:0] rand_first;
		logic [RAND_W-1:0] rand_second;
	} key_item_t;

	typedef struct packed {
		kcl_pkg::kcl_event_t ev;
		logic [COUNT_W-1:0]  entry_count;
		logic                door_open;
		logic                challenge_mode;
		logic [RAND_W-1:0]   challenge_first;
		logic [RAND_W-1:0]   challenge_second;
		logic [FAIL_W-1:0]   failures;
	} lock_result_t;

	typedef struct packed {
		logic [ENTRY_DEPTH-1:0][3:0] digits;
		logic [COUNT_W-1:0]          len;
		logic [FAIL_W-1:0]           fails;
		logic                        door;
		logic [RAND_W-1:0]           first;
		logic [RAND_W-1:0]           second;
	} lock_state_t;

	typedef struct packed {
		logic [CODE_W-1:0] code_bcd;
		logic [CLEN_W-1:0] code_length;
		logic [FAIL_W-1:0] fail_limit;
	} lock_cfg_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CODE_W-1:0]    cfg_data;

	kcl_in_if  keys_if();
	kcl_out_if result_if();

	keypad_code_lock_with_challenge_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.keys      (keys_if),
		.result    (result_if)
	);

	lock_cfg_t    lock_cfg;
	lock_state_t  lock_model;     // advanced at each accepted key
	lock_state_t  lock_plan;      // advanced as keys are queued, to shape sequences
	key_item_t    key_queue[$];
	lock_result_t expected_results[$];

	int keys_queued;
	int keys_accepted;
	int plan_items;
	int mismatches;
	int sender_idle_pct = 37;
	int receiver_idle_pct = 55;
	bit long_hold_armed;
	bit long_hold_taken;
	int rx_hold_left;
	int stall_cycles;

	always #5 clk = ~clk;

	function automatic lock_result_t lock_step(inout lock_state_t s, input key_item_t it);
		lock_result_t r;
		int unsigned value;
		int unsigned len;
		int i;
		bit hit;
		r.ev = kcl_pkg::EV_IGNORED;
		if (s.door) begin
			if (it.key_code == kcl_pkg::KEY_ENTER) begin
				s.door = 1'b0;
				r.ev = kcl_pkg::EV_CLOSED;
			end
		end else if (it.key_code <= kcl_pkg::KEY_DIGIT_MAX) begin
			if (s.len < ENTRY_DEPTH) begin
				s.digits[s.len[3:0]] = it.key_code;
				s.len++;
				r.ev = kcl_pkg::EV_DIGIT;
			end
		end else if (it.key_code == kcl_pkg::KEY_BACKSPACE) begin
			if (s.len > 0) begin
				s.len--;
				r.ev = kcl_pkg::EV_DELETED;
			end
		end else if (it.key_code == kcl_pkg::KEY_ENTER) begin
			if (s.fails >= lock_cfg.fail_limit) begin
				value = 0;
				for (i = 0; i < int'(s.len); i++) begin
					value = value * 10 + s.digits[i];
					if (value > kcl_pkg::VAL_CAP) value = kcl_pkg::VAL_CAP;
				end
				if (value == int'(s.first) + int'(s.second)) begin
					s.fails = '0;
					r.ev = kcl_pkg::EV_PASSED;
				end else begin
					if (s.fails < kcl_pkg::FAIL_MAX) s.fails++;
					r.ev = kcl_pkg::EV_WRONG;
				end
			end else begin
				len = (lock_cfg.code_length > CODE_DIGITS) ? CODE_DIGITS : lock_cfg.code_length;
				hit = (int'(s.len) == len);
				for (i = 0; i < int'(len); i++)
					if (s.digits[i] != lock_cfg.code_bcd[4*(len-1-i) +: 4]) hit = 1'b0;
				if (hit) begin
					s.door = 1'b1;
					s.fails = '0;
					r.ev = kcl_pkg::EV_UNLOCKED;
				end else begin
					if (s.fails < kcl_pkg::FAIL_MAX) s.fails++;
					r.ev = kcl_pkg::EV_WRONG;
				end
			end
			// redraw the sum challenge and clear the entry
			s.first = RAND_W'(int'(it.rand_first) % int'(kcl_pkg::CHAL_RANGE));
			s.second = RAND_W'(int'(it.rand_second)
				% (int'(kcl_pkg::CHAL_RANGE) - int'(s.first)));
			s.len = '0;
			s.digits = '0;
		end
		r.entry_count = s.len;
		r.door_open = s.door;
		r.challenge_mode = (s.fails >= lock_cfg.fail_limit);
		r.challenge_first = s.first;
		r.challenge_second = s.second;
		r.failures = s.fails;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] expd, logic [31:0] got);
		if (got !== expd) begin
			$error("%s: expected %0d, got %0d", name, expd, got);
			mismatches++;
		end
	endfunction

	function automatic logic [CODE_W-1:0] rand_bcd();
		logic [CODE_W-1:0] code;
		for (int i = 0; i < CODE_DIGITS; i++) code[4*i +: 4] = 4'($urandom_range(0, 9));
		return code;
	endfunction

	task automatic queue_key(input logic [KEY_W-1:0] key, input logic [RAND_W-1:0] r1,
			input logic [RAND_W-1:0] r2);
		key_item_t it;
		lock_result_t r;
		it = '{key_code: key, rand_first: r1, rand_second: r2};
		r = lock_step(lock_plan, it);
		if (r.ev != kcl_pkg::EV_IGNORED) plan_items++;
		key_queue.push_back(it);
		keys_queued++;
	endtask

	task automatic press(input logic [KEY_W-1:0] key);
		queue_key(key, RAND_W'($urandom_range(0, 16383)), RAND_W'($urandom_range(0, 16383)));
	endtask

	// one user interaction, chosen from the planned lock state
	task automatic plan_attempt();
		int pick;
		int n;
		int val;
		int unsigned len;
		logic [3:0] d;
		logic [3:0] digs[$];
		pick = $urandom_range(0, 99);
		if (lock_plan.door) begin
			if (pick < 30) begin
				d = 4'($urandom_range(0, 15));
				if (d == kcl_pkg::KEY_ENTER) d = kcl_pkg::KEY_BACKSPACE;
				press(d);
			end
			press(kcl_pkg::KEY_ENTER);
		end else if (pick < 45) begin
			if (lock_plan.fails >= lock_cfg.fail_limit) begin
				val = int'(lock_plan.first) + int'(lock_plan.second);
				do begin
					digs.push_front(4'(val % 10));
					val = val / 10;
				end while (val > 0);
				if ($urandom_range(0, 3) == 0) digs.push_front(4'd0);
			end else begin
				len = (lock_cfg.code_length > CODE_DIGITS) ? CODE_DIGITS : lock_cfg.code_length;
				for (int i = 0; i < int'(len); i++) begin
					d = lock_cfg.code_bcd[4*(len-1-i) +: 4];
					digs.push_back(d > kcl_pkg::KEY_DIGIT_MAX ? 4'($urandom_range(0, 9)) : d);
				end
			end
			// now and then spoil one digit
			if ($urandom_range(0, 9) == 0 && digs.size() > 0)
				digs[$urandom_range(0, digs.size() - 1)] = 4'($urandom_range(0, 9));
			foreach (digs[k]) begin
				if ($urandom_range(0, 5) == 0) begin
					press(4'($urandom_range(0, 9)));
					press(kcl_pkg::KEY_BACKSPACE);
				end
				press(digs[k]);
			end
			press(kcl_pkg::KEY_ENTER);
		end else if (pick < 65) begin
			n = $urandom_range(0, 8);
			repeat (n) press(4'($urandom_range(0, 9)));
			press(kcl_pkg::KEY_ENTER);
		end else if (pick < 75) begin
			// overfill the entry, trim a little, then submit a huge value
			n = $urandom_range(14, 20);
			repeat (n) press(4'($urandom_range(0, 9)));
			n = $urandom_range(0, 3);
			repeat (n) press(kcl_pkg::KEY_BACKSPACE);
			press(kcl_pkg::KEY_ENTER);
		end else begin
			n = $urandom_range(1, 6);
			repeat (n) press(4'($urandom_range(0, 15)));
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			kcl_pkg::CFG_CODE_BCD: lock_cfg.code_bcd = data;
			kcl_pkg::CFG_CODE_LENGTH: lock_cfg.code_length = data[CLEN_W-1:0];
			kcl_pkg::CFG_FAIL_LIMIT: lock_cfg.fail_limit = data[FAIL_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (!(keys_accepted == keys_queued && expected_results.size() == 0))
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// key driver
	always @(posedge clk or negedge arst_n) begin : key_driver
		key_item_t nxt;
		key_item_t taken;
		if (!arst_n) begin
			keys_if.valid <= 1'b0;
			keys_if.key_code <= '0;
			keys_if.rand_first <= '0;
			keys_if.rand_second <= '0;
		end else begin
			if (keys_if.valid && keys_if.ready) begin
				taken = {keys_if.key_code, keys_if.rand_first, keys_if.rand_second};
				expected_results.push_back(lock_step(lock_model, taken));
				keys_accepted++;
			end
			if (!keys_if.valid || keys_if.ready) begin
				if (key_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					nxt = key_queue.pop_front();
					keys_if.valid <= 1'b1;
					keys_if.key_code <= nxt.key_code;
					keys_if.rand_first <= nxt.rand_first;
					keys_if.rand_second <= nxt.rand_second;
				end else begin
					keys_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver back-pressure
	always @(posedge clk or negedge arst_n) begin : result_monitor
		lock_result_t want;
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			rx_hold_left <= 0;
			long_hold_taken <= 1'b0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no pending expectation");
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("event_res", want.ev, result_if.event_res);
					check_field("entry_count", want.entry_count, result_if.entry_count);
					check_field("door_open", want.door_open, result_if.door_open);
					check_field("challenge_mode", want.challenge_mode, result_if.challenge_mode);
					check_field("challenge_first", want.challenge_first,
						result_if.challenge_first);
					check_field("challenge_second", want.challenge_second,
						result_if.challenge_second);
					check_field("failures", want.failures, result_if.failures);
				end
			end
			if (long_hold_armed && !long_hold_taken) begin
				rx_hold_left <= LONG_HOLD_CYCLES;
				long_hold_taken <= 1'b1;
				result_if.ready <= 1'b0;
			end else if (rx_hold_left > 0) begin
				rx_hold_left <= rx_hold_left - 1;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((keys_if.valid && keys_if.ready) || (result_if.valid && result_if.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_CYCLES) begin
			$error("no transfer for %0d cycles", stall_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [CODE_W-1:0] code;
		logic [CODE_W-1:0] len;
		logic [CODE_W-1:0] limit;
		int start;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		lock_cfg = '{code_bcd: kcl_pkg::CODE_BCD_RST, code_length: kcl_pkg::CODE_LENGTH_RST,
			fail_limit: kcl_pkg::FAIL_LIMIT_RST};
		lock_model = '0;
		lock_plan = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ignored keys, the default code, open-door keys, wrong codes into
		// challenge mode, a passed challenge, and redraw operands at their extremes
		press(kcl_pkg::KEY_BACKSPACE);
		press(KEY_UNUSED_HI);
		press(KEY_UNUSED_LO);
		press(4'd7);
		press(4'd4);
		press(4'd1);
		queue_key(kcl_pkg::KEY_ENTER, 14'h3FFF, 14'h3FFF);
		press(4'd5);
		press(kcl_pkg::KEY_BACKSPACE);
		press(kcl_pkg::KEY_ENTER);
		press(4'd9);
		press(kcl_pkg::KEY_BACKSPACE);
		press(4'd0);
		queue_key(kcl_pkg::KEY_ENTER, 14'd0, 14'd0);
		queue_key(kcl_pkg::KEY_ENTER, 14'd5000, 14'd9999);
		queue_key(kcl_pkg::KEY_ENTER, 14'd9999, 14'd0);
		repeat (4) press(4'd9);
		queue_key(kcl_pkg::KEY_ENTER, 14'd0, 14'd9999);
		press(kcl_pkg::KEY_ENTER);
		drain();

		for (int s = 0; s < NUM_SETTINGS; s++) begin
			case (s)
				0: begin code = rand_bcd(); len = 6; limit = 1; end
				1: begin code = 24'hFFFFFF; len = 7; limit = 15; end
				2: begin code = '0; len = 0; limit = 0; end
				3: begin
					code = rand_bcd();
					len = $urandom_range(0, 5);
					limit = $urandom_range(1, 15);
				end
				4: begin code = CODE_W'($urandom); len = 7; limit = 2; end
				default: begin code = rand_bcd(); len = 3; limit = 3; end
			endcase
			if (s == 2) begin
				sender_idle_pct = 55;
				receiver_idle_pct = 37;
			end else if (s == 4) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			write_reg(kcl_pkg::CFG_CODE_BCD, code);
			write_reg(kcl_pkg::CFG_CODE_LENGTH, len);
			write_reg(kcl_pkg::CFG_FAIL_LIMIT, limit);
			start = plan_items;
			while (plan_items - start < ITEMS_PER_SETTING) plan_attempt();
			// stall the receiver while the sender keeps offering
			if (s == 4) long_hold_armed = 1'b1;
			drain();
		end

		repeat (20) @(posedge clk);
		if (expected_results.size() != 0)
			$error("%0d expected results never arrived", expected_results.size());
		if (mismatches == 0 && expected_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
